// File: sv/pjs_pkg.sv
// ----------------------------------------------------------------------------
// pjs_pkg
// Shared types and constants of the preemptive job scheduler.
// ----------------------------------------------------------------------------
package pjs_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic {
		FUNC_SUBMIT = 1'b0,
		FUNC_TICK   = 1'b1
	} func_t;

	typedef enum logic {
		POL_SRTF = 1'b0,
		POL_PRIO = 1'b1
	} policy_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_RAN    = 2'd2,
		KIND_IDLE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_PUSH
	} state_t;

	// one table entry as seen on the read port
	typedef struct packed {
		logic        valid;
		logic [7:0]  job;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} slot_t;

	// table update commands from the sequencer
	typedef struct packed {
		logic              alloc;
		logic              retire;
		logic              step;
		logic [SLOT_W-1:0] idx;
	} tbl_cmd_t;

	typedef struct packed {
		logic              full;
		logic [SLOT_W-1:0] free_idx;
	} tbl_stat_t;

endpackage

// File: sv/job_if.sv
// ----------------------------------------------------------------------------
// job_if
// Request channel: submit a job or advance one tick.
// ----------------------------------------------------------------------------
interface job_if import pjs_pkg::*;;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  job_id;
	logic [31:0] arrival;
	logic [15:0] burst;
	logic [7:0]  priority_req;

	modport source (output valid, func, job_id, arrival, burst, priority_req, input ready);
	modport sink   (input valid, func, job_id, arrival, burst, priority_req, output ready);
endinterface

// File: sv/res_if.sv
// ----------------------------------------------------------------------------
// res_if
// Result channel: one item per request.
// ----------------------------------------------------------------------------
interface res_if import pjs_pkg::*;;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  running_job;
	logic [31:0] now;
	logic        finished;
	logic [31:0] finish_time;
	logic [31:0] waiting_time;

	modport source (output valid, kind, running_job, now, finished, finish_time,
		waiting_time, input ready);
	modport sink   (input valid, kind, running_job, now, finished, finish_time,
		waiting_time, output ready);
endinterface

// File: sv/cfg_if.sv
// ----------------------------------------------------------------------------
// cfg_if
// Configuration write channel carrying the policy register.
// ----------------------------------------------------------------------------
interface cfg_if import pjs_pkg::*;;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: sv/pjs_table.sv
// ----------------------------------------------------------------------------
// pjs_table
// Job table: per-slot entries, one read port, lowest-free-slot encoder.
// ----------------------------------------------------------------------------
module pjs_table import pjs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_cmd_t          cmd,
	input  logic [7:0]        wr_job,
	input  logic [31:0]       wr_arrival,
	input  logic [15:0]       wr_burst,
	input  logic [7:0]        wr_prio,
	input  logic [SLOT_W-1:0] rd_idx,
	output slot_t             rd,
	output tbl_stat_t         stat
);

	logic [SLOTS-1:0] valid_q;
	logic [7:0]       job_q       [SLOTS];
	logic [31:0]      arrival_q   [SLOTS];
	logic [15:0]      burst_q     [SLOTS];
	logic [15:0]      remaining_q [SLOTS];
	logic [7:0]       prio_q      [SLOTS];

	// lowest free slot
	always_comb begin
		stat.full     = 1'b1;
		stat.free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				stat.full     = 1'b0;
				stat.free_idx = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.alloc && !stat.full) begin
			valid_q[stat.free_idx] <= 1'b1;
		end else if (cmd.retire) begin
			valid_q[cmd.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc && !stat.full) begin
			job_q[stat.free_idx]       <= wr_job;
			arrival_q[stat.free_idx]   <= wr_arrival;
			burst_q[stat.free_idx]     <= wr_burst;
			remaining_q[stat.free_idx] <= wr_burst;
			prio_q[stat.free_idx]      <= wr_prio;
		end else if (cmd.step) begin
			remaining_q[cmd.idx] <= remaining_q[cmd.idx] - 16'd1;
		end
	end

	always_comb begin
		rd.valid     = valid_q[rd_idx];
		rd.job       = job_q[rd_idx];
		rd.arrival   = arrival_q[rd_idx];
		rd.burst     = burst_q[rd_idx];
		rd.remaining = remaining_q[rd_idx];
		rd.prio      = prio_q[rd_idx];
	end

endmodule

// File: sv/preemptive_job_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_job_scheduler
// Tick-driven preemptive scheduler over a fixed job table.
// ----------------------------------------------------------------------------
// A submit item is stored in the lowest free slot (or rejected when the table
// is full). A tick item walks the table one slot per cycle through a single
// key comparator, then runs the chosen job and advances time. One item is
// worked on at a time; the result register lets the next item be accepted
// while a result still waits. policy selects shortest remaining time (0) or
// lowest priority number (1); ties go to the lowest slot.
module preemptive_job_scheduler import pjs_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	cfg_if.sink  cfg,
	job_if.sink  req,
	res_if.source rsp
);

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] scan_q;
	logic [SLOT_W-1:0] pick_q;
	logic [15:0]       best_q;
	logic              found_q;
	logic [31:0]       time_q;
	logic              policy_q;

	logic [1:0]  res_kind_q;
	logic [7:0]  res_job_q;
	logic [31:0] res_now_q;
	logic        res_fin_q;
	logic [31:0] res_finish_q;
	logic [31:0] res_wait_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_job_q;
	logic [31:0] out_now_q;
	logic        out_fin_q;
	logic [31:0] out_finish_q;
	logic [31:0] out_wait_q;

	tbl_cmd_t          cmd;
	tbl_stat_t         stat;
	slot_t             rd;
	logic [SLOT_W-1:0] rd_idx;
	logic              accept;
	logic              scan_last;
	logic              out_free;
	logic              load_out;
	logic [15:0]       key;
	logic              better;
	logic              done;
	logic [31:0]       fin_time;
	logic [31:0]       wait_time;

	pjs_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_job     (req.job_id),
		.wr_arrival (req.arrival),
		.wr_burst   (req.burst),
		.wr_prio    (req.priority_req),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.stat       (stat)
	);

	assign accept    = req.valid && req.ready;
	assign scan_last = (scan_q == SLOT_W'(SLOTS - 1));
	assign out_free  = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.func == FUNC_TICK) ? ST_SCAN : ST_PUSH;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_PUSH;
			ST_PUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		rd_idx     = (state_q == ST_SCAN) ? scan_q : pick_q;
		cmd.alloc  = accept && (req.func == FUNC_SUBMIT);
		cmd.step   = 1'b0;
		cmd.retire = 1'b0;
		cmd.idx    = pick_q;
		load_out   = (state_q == ST_PUSH) && out_free;
		if (state_q == ST_FINISH && found_q) begin
			cmd.step   = !done;
			cmd.retire = done;
		end
	end

	// shared comparator: scan key and the completion arithmetic
	always_comb begin
		key       = (policy_q == POL_PRIO) ? {8'd0, rd.prio} : rd.remaining;
		better    = rd.valid && (rd.arrival <= time_q) && (!found_q || key < best_q);
		done      = (rd.remaining <= 16'd1);
		fin_time  = time_q + 32'd1;
		wait_time = fin_time - rd.arrival - {16'd0, rd.burst};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			found_q     <= 1'b0;
			time_q      <= '0;
			policy_q    <= POL_SRTF;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				policy_q <= cfg.data;
			end
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (!scan_last) begin
					scan_q <= scan_q + SLOT_W'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_FINISH) begin
				time_q <= fin_time;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && better) begin
			pick_q <= scan_q;
			best_q <= key;
		end
		if (accept) begin
			res_kind_q   <= stat.full ? KIND_REJECT : KIND_ACCEPT;
			res_job_q    <= '0;
			res_now_q    <= time_q;
			res_fin_q    <= 1'b0;
			res_finish_q <= '0;
			res_wait_q   <= '0;
		end
		if (state_q == ST_FINISH) begin
			res_kind_q <= found_q ? KIND_RAN : KIND_IDLE;
			res_job_q  <= found_q ? rd.job : 8'd0;
			if (found_q && done) begin
				res_fin_q    <= 1'b1;
				res_finish_q <= fin_time;
				res_wait_q   <= wait_time;
			end
		end
		if (load_out) begin
			out_kind_q   <= res_kind_q;
			out_job_q    <= res_job_q;
			out_now_q    <= res_now_q;
			out_fin_q    <= res_fin_q;
			out_finish_q <= res_finish_q;
			out_wait_q   <= res_wait_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.running_job  = out_job_q;
	assign rsp.now          = out_now_q;
	assign rsp.finished     = out_fin_q;
	assign rsp.finish_time  = out_finish_q;
	assign rsp.waiting_time = out_wait_q;

endmodule
